### src/mm4_pkg.sv
package mm4_pkg;

    localparam int MAT_DIM = 4;
    localparam int Q_FRAC  = 16;
    localparam int ELEM_W  = 32;
    localparam int IDX_W   = $clog2(MAT_DIM);
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = PROD_W + IDX_W;
    localparam int PC_W    = 3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [PC_W-1:0]  t_pc;

    localparam t_idx IDX_LAST = IDX_W'(MAT_DIM - 1);

    // Item kinds carried on the slave tuser
    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    // Program step addresses
    localparam t_pc STEP_IDLE   = 3'd0;
    localparam t_pc STEP_FETCH  = 3'd1;
    localparam t_pc STEP_DRAIN0 = 3'd2;
    localparam t_pc STEP_DRAIN1 = 3'd3;
    localparam t_pc STEP_COL    = 3'd4;
    localparam t_pc STEP_EMIT   = 3'd5;
    localparam t_pc STEP_WRAP   = 3'd6;

    typedef enum logic [2:0] {
        C_NEXT   = 3'd0,
        C_CMD    = 3'd1,
        C_LOOP_K = 3'd2,
        C_LOOP_J = 3'd3,
        C_LOOP_I = 3'd4,
        C_JUMP   = 3'd5
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  clr;
        logic  fetch;
        logic  col;
        logic  emit;
        t_cond cond;
        t_pc   target;
    } t_uop;

    // Sequencer to datapath
    typedef struct packed {
        logic accept;
        logic clr;
        logic fetch;
        logic col;
        logic emit;
        t_idx i;
        t_idx j;
        t_idx k;
    } t_ctrl;

endpackage

### src/mm4_seq.sv
module mm4_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd,
    input  logic          i_out_free,
    output mm4_pkg::t_ctrl o_ctrl
);
    import mm4_pkg::*;

    function automatic t_uop rom(input t_pc addr);
        t_uop u;
        u = '{accept: 1'b0, clr: 1'b0, fetch: 1'b0, col: 1'b0, emit: 1'b0,
              cond: C_JUMP, target: STEP_IDLE};
        case (addr)
            STEP_IDLE: begin
                u.accept = 1'b1;
                u.clr    = 1'b1;
                u.cond   = C_CMD;
                u.target = STEP_FETCH;
            end
            STEP_FETCH: begin
                u.fetch  = 1'b1;
                u.cond   = C_LOOP_K;
                u.target = STEP_FETCH;
            end
            STEP_DRAIN0: u.cond = C_NEXT;
            STEP_DRAIN1: u.cond = C_NEXT;
            STEP_COL: begin
                u.col    = 1'b1;
                u.cond   = C_LOOP_J;
                u.target = STEP_FETCH;
            end
            STEP_EMIT: begin
                u.emit   = 1'b1;
                u.cond   = C_LOOP_I;
                u.target = STEP_FETCH;
            end
            STEP_WRAP: begin
                u.cond   = C_JUMP;
                u.target = STEP_IDLE;
            end
            default: u.cond = C_JUMP;
        endcase
        return u;
    endfunction

    t_pc  r_pc, n_pc;
    t_idx r_i, r_j, r_k;
    t_uop w_uop;
    logic w_hold;

    assign w_uop  = rom(r_pc);
    assign w_hold = w_uop.emit && !i_out_free;

    always_comb begin
        case (w_uop.cond)
            C_NEXT:   n_pc = r_pc + 1'b1;
            C_CMD:    n_pc = i_cmd ? w_uop.target : r_pc;
            C_LOOP_K: n_pc = (r_k != IDX_LAST) ? w_uop.target : r_pc + 1'b1;
            C_LOOP_J: n_pc = (r_j != IDX_LAST) ? w_uop.target : r_pc + 1'b1;
            C_LOOP_I: n_pc = w_hold ? r_pc :
                             ((r_i != IDX_LAST) ? w_uop.target : r_pc + 1'b1);
            C_JUMP:   n_pc = w_uop.target;
            default:  n_pc = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
        end else begin
            r_pc <= n_pc;
            if (w_uop.clr) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end else begin
                if (w_uop.fetch) r_k <= r_k + 1'b1;
                if (w_uop.col)   r_j <= r_j + 1'b1;
                if (w_uop.emit && !w_hold) r_i <= r_i + 1'b1;
            end
        end
    end

    assign o_ctrl = '{accept: w_uop.accept, clr: w_uop.clr, fetch: w_uop.fetch,
                      col: w_uop.col, emit: w_uop.emit && !w_hold,
                      i: r_i, j: r_j, k: r_k};

endmodule

### src/matrix_multiply_4x4.sv
// 4x4 matrix product C = A x B in signed Q16.16.
// Slave channel (s_*): one transaction per item. tuser carries the mode:
// load a row of A, load a row of B, or compute. tdata carries the row index
// and the four elements of a loaded row (ignored for compute). Mode 3 is
// taken and dropped.
// Master channel (m_*): a compute yields four transactions, rows 0..3 of C,
// the fourth marked by tlast; tuser flags a row in which any element clipped.
// Sequence: a load gives nothing back. A compute holds s_tready low while the
// sequencer works through the product, row 0 first, on the single shared
// 32x32 multiplier: four multiply steps per element, plus two drain steps
// and one rounding step, and one step per row to hand it out.
// When m_tready is low the finished row waits in the output register and
// the sequencer holds at its emit step until the register frees.
// Reset (synchronous, active low) clears both matrix stores to zero, empties
// the output register and returns the sequencer to its idle step.
module matrix_multiply_4x4 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave: [1:0] row_index, [33:2] elem0, [65:34] elem1, [97:66] elem2,
    //        [129:98] elem3, [135:130] zero
    input  logic [135:0] s_tdata,
    input  logic [1:0]   s_tuser,   // [1:0] mode
    input  logic         s_tvalid,
    output logic         s_tready,
    // master: [1:0] out_row, [33:2] prod0, [65:34] prod1, [97:66] prod2,
    //         [129:98] prod3, [135:130] zero
    output logic [135:0] m_tdata,
    output logic [0:0]   m_tuser,   // [0] saturated
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready
);
    import mm4_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'h7fff_ffff);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    t_ctrl w_ctrl;
    logic  w_s_accept, w_cmd, w_out_free;
    t_idx  w_row_idx;
    logic  [1:0] w_mode;

    logic signed [ELEM_W-1:0] r_left  [MAT_DIM*MAT_DIM];
    logic signed [ELEM_W-1:0] r_right [MAT_DIM*MAT_DIM];

    logic signed [ELEM_W-1:0] r_opa, r_opb;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v1, r_v2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_shift;
    logic signed [ELEM_W-1:0] w_clip;
    logic                     w_over, w_under;

    logic signed [ELEM_W-1:0] r_row [MAT_DIM];
    logic                     r_sat;

    logic                     r_m_valid, r_m_last, r_m_sat;
    t_idx                     r_m_row;
    logic signed [ELEM_W-1:0] r_m_prod [MAT_DIM];

    assign w_mode     = s_tuser;
    assign w_row_idx  = s_tdata[IDX_W-1:0];
    assign w_s_accept = s_tvalid && s_tready;
    assign w_cmd      = w_s_accept && (w_mode == MODE_COMPUTE);
    assign w_out_free = !r_m_valid || m_tready;
    assign s_tready   = w_ctrl.accept;

    mm4_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // Matrix stores: a load writes a whole row at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MAT_DIM*MAT_DIM; e++) begin
                r_left[e]  <= '0;
                r_right[e] <= '0;
            end
        end else if (w_s_accept) begin
            for (int c = 0; c < MAT_DIM; c++) begin
                if (w_mode == MODE_LOAD_A)
                    r_left[{w_row_idx, t_idx'(c)}] <= s_tdata[IDX_W + ELEM_W*c +: ELEM_W];
                if (w_mode == MODE_LOAD_B)
                    r_right[{w_row_idx, t_idx'(c)}] <= s_tdata[IDX_W + ELEM_W*c +: ELEM_W];
            end
        end
    end

    // MAC pipeline: fetch operands, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (w_ctrl.fetch) begin
            r_opa <= r_left[{w_ctrl.i, w_ctrl.k}];
            r_opb <= r_right[{w_ctrl.k, w_ctrl.j}];
        end
        r_prod <= r_opa * r_opb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= w_ctrl.fetch;
            r_v2 <= r_v1;
            if (w_ctrl.clr || w_ctrl.col)
                r_acc <= '0;
            else if (r_v2)
                r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Floor the exact sum back to Q16.16 and clip to 32 bits
    always_comb begin
        w_shift = r_acc >>> Q_FRAC;
        w_over  = w_shift > SAT_MAX;
        w_under = w_shift < SAT_MIN;
        if (w_over)
            w_clip = SAT_MAX[ELEM_W-1:0];
        else if (w_under)
            w_clip = SAT_MIN[ELEM_W-1:0];
        else
            w_clip = w_shift[ELEM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.col)
            r_row[w_ctrl.j] <= w_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_sat <= 1'b0;
        else if (w_ctrl.clr || w_ctrl.emit)
            r_sat <= 1'b0;
        else if (w_ctrl.col)
            r_sat <= r_sat | w_over | w_under;
    end

    // Output register: load on emit, drop once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_m_valid <= 1'b0;
        else if (w_ctrl.emit)
            r_m_valid <= 1'b1;
        else if (m_tready)
            r_m_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_m_row  <= w_ctrl.i;
            r_m_last <= (w_ctrl.i == IDX_LAST);
            r_m_sat  <= r_sat;
            for (int c = 0; c < MAT_DIM; c++)
                r_m_prod[c] <= r_row[c];
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tlast  = r_m_last;
    assign m_tuser  = r_m_sat;
    assign m_tdata  = {6'b0, r_m_prod[3], r_m_prod[2], r_m_prod[1], r_m_prod[0],
                       r_m_row};

`ifndef SYNTHESIS
    // A taken compute closes the slave side
    a_cmd_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd |=> !s_tready)
        else $error("slave ready after compute accepted");

    // Rows before the last leave while the sequencer is still busy
    a_busy_midrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("sequencer idle with rows outstanding");

    // The MAC pipeline is empty when an element is rounded
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.col |-> (!r_v1 && !r_v2 && w_ctrl.k == '0))
        else $error("rounding with products in flight");

    // The marked row is row three
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (r_m_row == IDX_LAST)))
        else $error("tlast on wrong row");
`endif

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mm4_pkg::*;

    // Mode 3 has no name in the package: the block takes the transaction and drops it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 7;
    localparam int     RANDOM_ITEMS  = 400;
    localparam int     MAX_WAIT      = 13;
    localparam int     SINK_HOLD     = 300;  // long receiver hold-off, in cycles
    localparam int     HOLD_AT_ROW   = 20;   // product row after which the hold starts
    localparam int     SETTLE_CYCLES = 150;  // final wait for stray rows, in cycles
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint S32_MAX       = 64'sd2147483647;
    localparam longint S32_MIN       = -64'sd2147483648;

    typedef logic [MAT_DIM-1:0][ELEM_W-1:0] t_row_elems;

    // One slave transaction: a row load or a compute command.
    typedef struct {
        logic [1:0] mode;
        t_idx       row;
        t_row_elems elem;
        bit         drain_first;  // hold until every product row is back
    } t_matrix_cmd;

    // One master transaction: one row of C.
    typedef struct packed {
        t_idx       row;
        t_row_elems prod;
        logic       sat;
        logic       last;
    } t_product_row;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic [135:0] s_tdata  = '0;  // [1:0] row_index, [33:2] elem0 .. [129:98] elem3, zero
    logic [1:0]   s_tuser  = '0;  // [1:0] mode
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] m_tdata;        // [1:0] out_row, [33:2] prod0 .. [129:98] prod3, zero
    logic [0:0]   m_tuser;        // [0] saturated
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;

    matrix_multiply_4x4 dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copies of the two matrix stores, starting cleared like the block after reset.
    logic signed [ELEM_W-1:0] store_a [MAT_DIM][MAT_DIM] = '{default: '0};
    logic signed [ELEM_W-1:0] store_b [MAT_DIM][MAT_DIM] = '{default: '0};

    t_matrix_cmd  cmd_queue[$];      // commands still to be offered
    t_product_row product_rows_due[$];
    t_matrix_cmd  cur_cmd;
    t_product_row got_row;
    t_product_row want_row;

    int  cmds_total    = 0;
    int  cmds_taken    = 0;
    int  rows_taken    = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  src_wait      = 0;
    int  sink_wait     = 0;
    bit  src_calm      = 1'b0;
    bit  sink_calm     = 1'b0;
    bit  sink_held     = 1'b0;

    // Apply one accepted command to the shadow stores; on a compute, queue the
    // four rows of C = A x B. Each element is summed exactly at Q32.32 in 66 bits
    // (four products of up to 2^62 each), floored by the arithmetic shift, then
    // clipped to 32 bits.
    function automatic void apply_cmd(input t_matrix_cmd c);
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        logic signed [65:0] acc;
        logic signed [65:0] shifted;
        t_product_row       r;
        case (c.mode)
            MODE_LOAD_A: begin
                for (int j = 0; j < MAT_DIM; j++) store_a[c.row][j] = c.elem[j];
            end
            MODE_LOAD_B: begin
                for (int j = 0; j < MAT_DIM; j++) store_b[c.row][j] = c.elem[j];
            end
            MODE_COMPUTE: begin
                for (int i = 0; i < MAT_DIM; i++) begin
                    r.row  = t_idx'(i);
                    r.sat  = 1'b0;
                    r.last = (i == MAT_DIM - 1);
                    for (int j = 0; j < MAT_DIM; j++) begin
                        acc = '0;
                        for (int k = 0; k < MAT_DIM; k++) begin
                            pa  = 64'(store_a[i][k]);
                            pb  = 64'(store_b[k][j]);
                            acc = acc + 66'(pa * pb);
                        end
                        shifted = acc >>> Q_FRAC;
                        if (shifted > 66'(S32_MAX)) begin
                            r.prod[j] = 32'h7FFF_FFFF;
                            r.sat     = 1'b1;
                        end else if (shifted < 66'(S32_MIN)) begin
                            r.prod[j] = 32'h8000_0000;
                            r.sat     = 1'b1;
                        end else begin
                            r.prod[j] = shifted[ELEM_W-1:0];
                        end
                    end
                    product_rows_due.push_back(r);
                end
            end
            default: begin
                // unused mode: drop
            end
        endcase
    endfunction

    function automatic void queue_cmd(input logic [1:0] mode, input t_idx row,
                                      input t_row_elems elem, input bit drain_first);
        t_matrix_cmd c;
        c.mode        = mode;
        c.row         = row;
        c.elem        = elem;
        c.drain_first = drain_first;
        cmd_queue.push_back(c);
    endfunction

    // Mostly small and medium Q16.16 values so that many sums stay in range;
    // full-range words and the extremes now and then to drive clipping.
    function automatic t_row_elems random_elems();
        t_row_elems e;
        int         sel;
        for (int j = 0; j < MAT_DIM; j++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                e[j] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            end else if (sel < 75) begin
                e[j] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end else if (sel < 93) begin
                e[j] = $urandom;
            end else begin
                case ($urandom_range(0, 3))
                    0:       e[j] = 32'h7FFF_FFFF;
                    1:       e[j] = 32'h8000_0000;
                    2:       e[j] = 32'hFFFF_FFFF;
                    default: e[j] = 32'h0000_0001;
                endcase
            end
        end
        return e;
    endfunction

    // Draw a per-transaction wait; now and then switch into or out of a
    // stretch with no waits at all.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 24) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void flag_mismatch(input string what, input string want_s,
                                          input string got_s);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %s, got %s", what, want_s, got_s);
    endfunction

    // Driver: offer commands from the queue, hold each until the block takes it,
    // then wait the drawn number of cycles before the next one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                apply_cmd(cur_cmd);
                cmds_taken++;
                src_wait = draw_wait(src_calm);
            end
            if (s_tvalid && !s_tready) begin
                // hold the current transaction
            end else if (src_wait > 0) begin
                src_wait--;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].drain_first && product_rows_due.size() != 0)) begin
                cur_cmd = cmd_queue.pop_front();
                s_tdata  <= {6'b0, cur_cmd.elem, cur_cmd.row};
                s_tuser  <= cur_cmd.mode;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall a drawn number of cycles after each product row; once,
    // hold off for a long stretch so the output register and then the input fill.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            rows_taken++;
            if (rows_taken == HOLD_AT_ROW && !sink_held) begin
                sink_held = 1'b1;
                sink_wait = SINK_HOLD;
            end else begin
                sink_wait = draw_wait(sink_calm);
            end
        end
        if (sink_wait > 0) begin
            sink_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: compare each product row with the oldest predicted one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_row.row  = m_tdata[IDX_W-1:0];
            got_row.prod = m_tdata[IDX_W +: MAT_DIM*ELEM_W];
            got_row.sat  = m_tuser[0];
            got_row.last = m_tlast;
            if (product_rows_due.size() == 0) begin
                flag_mismatch("product row", "none pending",
                              $sformatf("out_row %0d", got_row.row));
            end else begin
                want_row = product_rows_due.pop_front();
                if (got_row.row !== want_row.row)
                    flag_mismatch("out_row", $sformatf("%0d", want_row.row),
                                  $sformatf("%0d", got_row.row));
                for (int j = 0; j < MAT_DIM; j++) begin
                    if (got_row.prod[j] !== want_row.prod[j])
                        flag_mismatch($sformatf("row %0d prod%0d", want_row.row, j),
                                      $sformatf("%h", want_row.prod[j]),
                                      $sformatf("%h", got_row.prod[j]));
                end
                if (got_row.sat !== want_row.sat)
                    flag_mismatch($sformatf("row %0d saturated", want_row.row),
                                  $sformatf("%b", want_row.sat),
                                  $sformatf("%b", got_row.sat));
                if (got_row.last !== want_row.last)
                    flag_mismatch($sformatf("row %0d tlast", want_row.row),
                                  $sformatf("%b", want_row.last),
                                  $sformatf("%b", got_row.last));
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_row_elems e;
        int         counted;
        int         batch;
        int         n_loads;
        logic [1:0] m;

        // Directed: compute on cleared stores, with a row index that must be ignored.
        queue_cmd(MODE_COMPUTE, 2'd2, random_elems(), 1'b0);
        // Unused mode with a full row of data: no result, no store change.
        queue_cmd(MODE_UNUSED, 2'd3, random_elems(), 1'b0);
        // A = identity, B = rows of extreme words, so C = B.
        for (int r = 0; r < MAT_DIM; r++) begin
            e    = '0;
            e[r] = 32'h0001_0000;
            queue_cmd(MODE_LOAD_A, t_idx'(r), e, 1'b0);
        end
        queue_cmd(MODE_LOAD_B, 2'd0, {32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                                      32'h7FFF_FFFF}, 1'b0);
        queue_cmd(MODE_LOAD_B, 2'd1, {32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                                      32'h8000_0000}, 1'b0);
        queue_cmd(MODE_LOAD_B, 2'd2, {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                                      32'hFFFF_FFFF}, 1'b0);
        queue_cmd(MODE_LOAD_B, 2'd3, {32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h0000_0001}, 1'b0);
        queue_cmd(MODE_COMPUTE, 2'd1, '0, 1'b0);
        // Clip high (min x min, sum 2^64), clip low (max x min), and a small
        // positive result from -1 x min; row 3 of A stays an identity row.
        queue_cmd(MODE_LOAD_A, 2'd0, {MAT_DIM{32'h8000_0000}}, 1'b0);
        queue_cmd(MODE_LOAD_A, 2'd1, {MAT_DIM{32'h7FFF_FFFF}}, 1'b0);
        queue_cmd(MODE_LOAD_A, 2'd2, {MAT_DIM{32'hFFFF_FFFF}}, 1'b0);
        for (int r = 0; r < MAT_DIM; r++)
            queue_cmd(MODE_LOAD_B, t_idx'(r), {MAT_DIM{32'h8000_0000}}, 1'b0);
        queue_cmd(MODE_COMPUTE, 2'd0, '0, 1'b0);
        // Tiny negative products (-1 x 1) in row 2 of C.
        queue_cmd(MODE_LOAD_B, 2'd0, {MAT_DIM{32'h0000_0001}}, 1'b0);
        queue_cmd(MODE_LOAD_B, 2'd1, {MAT_DIM{32'h7FFF_FFFF}}, 1'b0);
        queue_cmd(MODE_COMPUTE, 2'd3, '0, 1'b0);

        // Random: mostly a few row loads followed by a compute, some lone noise
        // items of any mode. Twice, hold a batch until every row is back.
        counted = 0;
        batch   = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                n_loads = $urandom_range(1, 2 * MAT_DIM);
                for (int l = 0; l < n_loads; l++) begin
                    m = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
                    queue_cmd(m, t_idx'($urandom_range(0, MAT_DIM - 1)), random_elems(),
                              l == 0 && (batch == 12 || batch == 45));
                end
                queue_cmd(MODE_COMPUTE, t_idx'($urandom_range(0, MAT_DIM - 1)),
                          random_elems(), 1'b0);
                counted += n_loads + 1;
                batch++;
            end else begin
                m = 2'($urandom_range(0, 3));
                queue_cmd(m, t_idx'($urandom_range(0, MAT_DIM - 1)), random_elems(),
                          1'b0);
                if (m != MODE_UNUSED) counted++;
            end
        end
        cmds_total = cmd_queue.size();

        // Release reset after the required cycles; drive it at a rising edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to be taken and every product row to arrive,
        // then let the block settle so stray rows show up.
        while (cmds_taken < cmds_total || product_rows_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && product_rows_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### files.f
src/mm4_pkg.sv
src/mm4_seq.sv
src/matrix_multiply_4x4.sv
test/tb.sv
